// ===== rtl/ned_pkg.sv =====
// Shared types and constants for the neighbour difference edge detector.
// No dependencies; ned_window, ned_calc and the top level import this package.
package ned_pkg;

    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int COLOR_W   = 8;
    // One pixel difference is at most 3 * 255, four of them at most 4 * 765
    localparam int PD_W      = 10;
    localparam int SUM_W     = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_COLOR   = 2'd3;

    localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RST = 12'd480;
    localparam logic [COLOR_W-1:0] TOLERANCE_RST    = 8'd0;
    localparam logic [COLOR_W-1:0] EDGE_COLOR_RST   = 8'd255;
    localparam logic [COLOR_W-1:0] GREY_MAX         = 8'd255;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } rgb_t;

    // One line store entry: the pixel two rows up and the pixel one row up
    typedef struct packed {
        rgb_t up;
        rgb_t mid;
    } entry_t;

    // Neighbourhood of one centre pixel, handed from the line store to the datapath
    typedef struct packed {
        rgb_t center;
        rgb_t up;
        rgb_t down;
        rgb_t left;
        rgb_t right;
        logic use_up;
        logic use_down;
        logic use_left;
        logic use_right;
        logic last;
    } nbh_t;

endpackage

// ===== rtl/ned_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; contents are undefined after reset.
module ned_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ned_window.sv =====
// Line store and raster control: column/row counters, read-ahead window over the
// two-row RAM with write bypass, and the registered neighbourhood stage.
// Depends on ned_pkg and ned_ram.
module ned_window
    import ned_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic [$clog2(MAX_WIDTH)-1:0]                 last_col,
    input  logic [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1)-1:0] last_row,
    input  logic                                         pixel_valid,
    output logic                                         pixel_stall,
    input  logic                                         command,
    input  rgb_t                                         pixel,
    output logic                                         nbh_valid,
    output nbh_t                                         nbh,
    input  logic                                         nbh_stall
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             draining_reg, draining_next;
    rgb_t             left_reg, left_next;
    entry_t           cur_reg, cur_next;
    entry_t           nxt_reg;
    logic             fresh_reg;
    logic             byp_hit_reg;
    entry_t           byp_data_reg;
    logic             nbh_valid_reg, nbh_valid_next;
    nbh_t             nbh_reg, nbh_next;

    logic             accept;
    logic             do_pixel;
    logic             do_drain;
    logic             step;
    logic             produce;
    logic             row_end;
    logic             has_row;
    logic [COL_W-1:0] col_succ;
    logic [COL_W-1:0] rd_addr;
    entry_t           rd_data;
    entry_t           nxt_eff;
    entry_t           wr_data;

    function automatic logic [COL_W-1:0] succ(input logic [COL_W-1:0] x,
                                              input logic [COL_W-1:0] lim);
        return (x >= lim) ? '0 : COL_W'(x + 1'b1);
    endfunction

    assign accept   = pixel_valid && !pixel_stall;
    assign do_pixel = accept && (command == CMD_PIXEL) && !draining_reg;
    assign do_drain = accept && (command == CMD_DRAIN) && draining_reg;
    assign step     = do_pixel || do_drain;
    assign has_row  = (row_reg != '0);
    assign produce  = do_drain || (do_pixel && has_row);
    assign row_end  = (col_reg >= last_col);

    // Read two columns ahead so that centre and right neighbour are ready in time
    assign col_succ = succ(col_reg, last_col);
    assign rd_addr  = succ(col_succ, last_col);

    assign nxt_eff = fresh_reg ? (byp_hit_reg ? byp_data_reg : rd_data) : nxt_reg;

    assign wr_data.up  = has_row ? cur_reg.mid : cur_reg.up;
    assign wr_data.mid = pixel;

    ned_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk    (clk),
        .wr_en  (do_pixel),
        .wr_addr(col_reg),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        left_next     = left_reg;
        cur_next      = cur_reg;
        if (step)
        begin
            col_next = col_succ;
            // A one-column frame wraps onto the entry just written
            cur_next = (do_pixel && (col_succ == col_reg)) ? wr_data : nxt_eff;
            if (do_drain || has_row)
            begin
                left_next = cur_reg.mid;
            end
            if (row_end)
            begin
                left_next = '0;
                if (do_drain)
                begin
                    row_next      = '0;
                    draining_next = 1'b0;
                end
                else if (row_reg >= last_row)
                begin
                    draining_next = 1'b1;
                end
                else
                begin
                    row_next = ROW_W'(row_reg + 1'b1);
                end
            end
        end
    end

    always_comb
    begin
        nbh_next.center    = cur_reg.mid;
        nbh_next.up        = cur_reg.up;
        nbh_next.down      = pixel;
        nbh_next.left      = left_reg;
        nbh_next.right     = nxt_eff.mid;
        nbh_next.use_left  = (col_reg != '0);
        nbh_next.use_right = !row_end;
        if (do_drain)
        begin
            nbh_next.use_up   = has_row;
            nbh_next.use_down = 1'b0;
            nbh_next.last     = row_end;
        end
        else
        begin
            nbh_next.use_up   = (row_reg > ROW_W'(1));
            nbh_next.use_down = 1'b1;
            nbh_next.last     = 1'b0;
        end
    end

    always_comb
    begin
        if (produce)
        begin
            nbh_valid_next = 1'b1;
        end
        else if (nbh_stall)
        begin
            nbh_valid_next = nbh_valid_reg;
        end
        else
        begin
            nbh_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            draining_reg  <= 1'b0;
            left_reg      <= '0;
            fresh_reg     <= 1'b0;
            byp_hit_reg   <= 1'b0;
            nbh_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            draining_reg  <= draining_next;
            left_reg      <= left_next;
            fresh_reg     <= step;
            byp_hit_reg   <= do_pixel && (col_reg == rd_addr);
            nbh_valid_reg <= nbh_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        nxt_reg      <= nxt_eff;
        byp_data_reg <= wr_data;
        if (produce)
        begin
            nbh_reg <= nbh_next;
        end
    end

    assign pixel_stall = nbh_valid_reg && nbh_stall;
    assign nbh_valid   = nbh_valid_reg;
    assign nbh         = nbh_reg;

endmodule

// ===== rtl/ned_calc.sv =====
// Difference datapath: per-neighbour absolute RGB differences, saturated sum,
// threshold (or grey sum at zero tolerance), output register. Depends on ned_pkg.
module ned_calc
    import ned_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COLOR_W-1:0] tolerance,
    input  logic [COLOR_W-1:0] edge_color,
    input  logic               nbh_valid,
    input  nbh_t               nbh,
    output logic               nbh_stall,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [COLOR_W-1:0] edge_value,
    output logic               frame_last
);

    logic              b_valid_reg, b_valid_next;
    logic [PD_W-1:0]   d_up_reg, d_down_reg, d_left_reg, d_right_reg;
    logic              b_last_reg;
    logic              out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0] edge_value_reg, edge_value_next;
    logic              frame_last_reg;

    logic              c_adv;
    logic              b_load;
    logic [SUM_W-1:0]  sum;
    logic [COLOR_W-1:0] sat;

    function automatic logic [COLOR_W-1:0] absdiff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
        return (a > b) ? COLOR_W'(a - b) : COLOR_W'(b - a);
    endfunction

    function automatic logic [PD_W-1:0] pix_diff(input rgb_t a, input rgb_t b);
        return PD_W'(absdiff(a.red, b.red)) + PD_W'(absdiff(a.green, b.green))
             + PD_W'(absdiff(a.blue, b.blue));
    endfunction

    assign c_adv     = !out_valid_reg || !result_stall;
    assign b_load    = !b_valid_reg || c_adv;
    assign nbh_stall = b_valid_reg && !c_adv;

    assign b_valid_next   = b_load ? nbh_valid : b_valid_reg;
    assign out_valid_next = c_adv ? b_valid_reg : out_valid_reg;

    assign sum = SUM_W'(d_up_reg) + SUM_W'(d_down_reg)
               + SUM_W'(d_left_reg) + SUM_W'(d_right_reg);
    assign sat = (sum > SUM_W'(GREY_MAX)) ? GREY_MAX : sum[COLOR_W-1:0];

    always_comb
    begin
        if (tolerance == '0)
        begin
            edge_value_next = sat;
        end
        else if (sat > tolerance)
        begin
            edge_value_next = edge_color;
        end
        else
        begin
            edge_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load && nbh_valid)
        begin
            d_up_reg    <= nbh.use_up    ? pix_diff(nbh.up, nbh.center)    : '0;
            d_down_reg  <= nbh.use_down  ? pix_diff(nbh.down, nbh.center)  : '0;
            d_left_reg  <= nbh.use_left  ? pix_diff(nbh.left, nbh.center)  : '0;
            d_right_reg <= nbh.use_right ? pix_diff(nbh.right, nbh.center) : '0;
            b_last_reg  <= nbh.last;
        end
        if (c_adv && b_valid_reg)
        begin
            edge_value_reg <= edge_value_next;
            frame_last_reg <= b_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign edge_value   = edge_value_reg;
    assign frame_last   = frame_last_reg;

endmodule

// ===== rtl/neighbour_difference_edge_detect.sv =====
// Four-neighbour absolute difference edge detector, top level. Depends on ned_pkg.
// Throughput: one beat per cycle while pixel_stall is low; the line store RAM
// takes one write and one read-ahead read per beat. After the beat completing a
// pixel's lower neighbour, its result passes neighbourhood, difference and output registers.
// Reset clears counters, valids and the configuration to its defaults; line store
// contents stay undefined until written and get no clearing pass.
module neighbour_difference_edge_detect
    import ned_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 pixel_valid,
    output logic                 pixel_stall,
    input  logic                 command,
    input  logic [COLOR_W-1:0]   red,
    input  logic [COLOR_W-1:0]   green,
    input  logic [COLOR_W-1:0]   blue,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [COLOR_W-1:0]   edge_value,
    output logic                 frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;

    logic [COL_W-1:0]   last_col_reg;
    logic [ROW_W-1:0]   last_row_reg;
    logic [COLOR_W-1:0] tolerance_reg;
    logic [COLOR_W-1:0] edge_color_reg;

    rgb_t pixel;
    logic nbh_valid;
    nbh_t nbh;
    logic nbh_stall;

    // Clamp a size to 1..max and return it minus one
    function automatic logic [COL_W-1:0] last_col_of(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return '0;
        end
        else if (32'(v) > MAX_WIDTH)
        begin
            return COL_W'(MAX_WIDTH - 1);
        end
        return COL_W'(v - 1'b1);
    endfunction

    function automatic logic [ROW_W-1:0] last_row_of(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return '0;
        end
        else if (32'(v) > MAX_HEIGHT)
        begin
            return ROW_W'(MAX_HEIGHT - 1);
        end
        return ROW_W'(v - 1'b1);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg   <= last_col_of(FRAME_WIDTH_RST);
            last_row_reg   <= last_row_of(FRAME_HEIGHT_RST);
            tolerance_reg  <= TOLERANCE_RST;
            edge_color_reg <= EDGE_COLOR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  last_col_reg   <= last_col_of(cfg_data);
                REG_FRAME_HEIGHT: last_row_reg   <= last_row_of(cfg_data);
                REG_TOLERANCE:    tolerance_reg  <= cfg_data[COLOR_W-1:0];
                REG_EDGE_COLOR:   edge_color_reg <= cfg_data[COLOR_W-1:0];
            endcase
        end
    end

    assign pixel.red   = red;
    assign pixel.green = green;
    assign pixel.blue  = blue;

    ned_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .last_col   (last_col_reg),
        .last_row   (last_row_reg),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .command    (command),
        .pixel      (pixel),
        .nbh_valid  (nbh_valid),
        .nbh        (nbh),
        .nbh_stall  (nbh_stall)
    );

    ned_calc u_calc (
        .clk         (clk),
        .rst_n       (rst_n),
        .tolerance   (tolerance_reg),
        .edge_color  (edge_color_reg),
        .nbh_valid   (nbh_valid),
        .nbh         (nbh),
        .nbh_stall   (nbh_stall),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .edge_value  (edge_value),
        .frame_last  (frame_last)
    );

`ifndef SYNTH
    // Back-pressure into the line store only comes from a held output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        nbh_stall |-> result_valid && result_stall)
        else $error("datapath stalls without a held output beat");

    // Only a drain beat closes the frame, and a drain has no lower neighbour
    assert property (@(posedge clk) disable iff (!rst_n)
        nbh_valid && nbh.last |-> !nbh.use_down)
        else $error("frame end flagged on a pixel beat");

    // A new output beat is always two stages behind a neighbourhood
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(nbh_valid, 2))
        else $error("output beat without a neighbourhood behind it");
`endif

endmodule
